// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// A condition that must be followed by another in the next cycle.
`define ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, prop)
`define ASSERT_NEXT(label, pre, post)

`endif

`endif

// ===== rtl/core/iks_pkg.sv =====
// ----------------------------------------------------------------------------
// iks_pkg
// Types, constants and helper functions of the IK solution selector.
// ----------------------------------------------------------------------------
package iks_pkg;

	// Item and joint geometry.
	localparam int NumJoints = 6;
	localparam int InAngW    = 18;
	localparam int OutAngW   = 17;
	localparam int IdxW      = 3;
	localparam int LimW      = 36;
	localparam int WeightW   = 4;
	localparam int WeightsW  = NumJoints * WeightW;

	// Selection set size and limit widening.
	localparam int MaxCand   = 8;
	localparam int CntW      = $clog2(MaxCand + 1);
	localparam int Tolerance = 1;

	// One full turn in hundredths of a degree.
	localparam int Turn = 36000;

	// Angles and limits span less than nine turns, so nine thresholds
	// cover every wrap count in either direction.
	localparam int WrapSteps = 9;
	localparam int KW        = $clog2(WrapSteps + 1);

	// Internal arithmetic widths.
	localparam int AngW      = 20;
	localparam int DW        = 21;
	localparam int DiffW     = 19;
	localparam int SqW       = 2 * DiffW;
	localparam int LaneCostW = SqW + WeightW;
	localparam int PairW     = LaneCostW + 1;
	localparam int CostW     = 48;

	// Configuration register indexes beyond the per-joint limits.
	localparam logic [2:0] CfgWeights  = 3'd6;
	localparam logic [2:0] CfgBiasMask = 3'd7;

	// Configuration reset values.
	localparam logic [LimW-1:0]      LimitsReset  = 36'd9437410144;
	localparam logic [WeightsW-1:0]  WeightsReset = 24'd1135957;
	localparam logic [NumJoints-1:0] BiasReset    = 6'd57;

	// Control word that travels beside the lane data.
	typedef struct packed {
		logic            valid;
		logic            eval;
		logic            last;
		logic [CntW-1:0] pos;
	} iks_ctl_t;

	// Number of whole turns needed to bring a positive excess to zero or below.
	function automatic logic [KW-1:0] wrap_count(input logic signed [AngW-1:0] diff);
		logic [WrapSteps-1:0] gt;
		for (int i = 0; i < WrapSteps; i++) begin
			gt[i] = diff > signed'(AngW'(i * Turn));
		end
		return KW'($countones(gt));
	endfunction

	// A count of turns expressed in hundredths.
	function automatic logic signed [AngW-1:0] turn_mult(input logic [KW-1:0] k);
		return signed'(AngW'(int'(k) * Turn));
	endfunction

endpackage

// ===== rtl/core/iks_lane.sv =====
// ----------------------------------------------------------------------------
// iks_lane
// One joint lane: wraps the candidate angle into the widened limits, checks
// it, and forms the weighted squared distance to the current angle.
// ----------------------------------------------------------------------------
module iks_lane (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [iks_pkg::InAngW-1:0]   angle,
	input  logic signed [iks_pkg::InAngW-1:0]   cur,
	input  logic [iks_pkg::LimW-1:0]            limits,
	input  logic [iks_pkg::WeightW-1:0]         weight,
	input  logic                                bias,
	output logic [iks_pkg::LaneCostW-1:0]       wcost,
	output logic                                ok,
	output logic signed [iks_pkg::OutAngW-1:0]  mapped
);
	import iks_pkg::*;

	logic signed [AngW-1:0]   lo;
	logic signed [AngW-1:0]   hi;
	logic signed [AngW-1:0]   a_ext;
	logic signed [AngW-1:0]   a1;
	logic signed [AngW-1:0]   map_c;
	logic signed [AngW-1:0]   mag;
	logic signed [DW-1:0]     d_map;
	logic signed [DW-1:0]     d_cur;
	logic signed [DW-1:0]     d_bias;
	logic signed [DW-1:0]     d;
	logic signed [DW-1:0]     d_abs;

	logic signed [AngW-1:0]   a1_s1;
	logic signed [InAngW-1:0] cur_s1;
	logic signed [AngW-1:0]   map_s2;
	logic signed [InAngW-1:0] cur_s2;
	logic                     ok_s2;
	logic [DiffW-1:0]         dabs_s3;
	logic signed [AngW-1:0]   map_s3;
	logic                     ok_s3;
	logic [SqW-1:0]           sq_s4;
	logic signed [AngW-1:0]   map_s4;
	logic                     ok_s4;
	logic [LaneCostW-1:0]     wc_s5;
	logic signed [AngW-1:0]   map_s5;
	logic                     ok_s5;

	// Limits widened by the tolerance; the user, not the block, keeps them stable while items are in flight.
	assign lo = AngW'(signed'(limits[InAngW-1:0])) - signed'(AngW'(Tolerance));
	assign hi = AngW'(signed'(limits[LimW-1:InAngW])) + signed'(AngW'(Tolerance));

	// Stage 1 adds whole turns while the angle lies below the lower limit.
	assign a_ext = AngW'(angle);
	assign a1    = a_ext + turn_mult(wrap_count(lo - a_ext));

	// Stage 2 removes whole turns while above the upper limit, then checks.
	assign map_c = a1_s1 - turn_mult(wrap_count(a1_s1 - hi));

	// Stage 3 forms the distance, with the magnitude term on biased joints.
	always_comb begin
		mag    = (map_s2 < 0) ? -map_s2 : map_s2;
		d_map  = DW'(map_s2);
		d_cur  = DW'(cur_s2);
		d_bias = bias ? DW'(mag) : DW'(0);
		d      = d_map - d_cur + d_bias;
		d_abs  = (d < 0) ? -d : d;
	end

	// Lane pipeline; the whole chain holds while the block is stalled.
	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1   <= a1;
			cur_s1  <= cur;
			map_s2  <= map_c;
			cur_s2  <= cur_s1;
			ok_s2   <= (map_c > lo) && (map_c < hi);
			dabs_s3 <= d_abs[DiffW-1:0];
			map_s3  <= map_s2;
			ok_s3   <= ok_s2;
			sq_s4   <= dabs_s3 * dabs_s3;
			map_s4  <= map_s3;
			ok_s4   <= ok_s3;
			wc_s5   <= LaneCostW'(sq_s4) * LaneCostW'(weight);
			map_s5  <= map_s4;
			ok_s5   <= ok_s4;
		end
	end

	assign wcost  = wc_s5;
	assign ok     = ok_s5;
	assign mapped = map_s5[OutAngW-1:0];

endmodule

// ===== rtl/core/iks_merge.sv =====
// ----------------------------------------------------------------------------
// iks_merge
// Sums the lane costs, keeps the running best candidate of the set and
// holds the result item until it is taken.
// ----------------------------------------------------------------------------
module iks_merge (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  iks_pkg::iks_ctl_t                  ctl_s5,
	input  logic [iks_pkg::LaneCostW-1:0]      wcost  [iks_pkg::NumJoints],
	input  logic                               ok     [iks_pkg::NumJoints],
	input  logic signed [iks_pkg::OutAngW-1:0] mapped [iks_pkg::NumJoints],
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [iks_pkg::IdxW-1:0]           best_index,
	output logic                               found,
	output logic signed [iks_pkg::OutAngW-1:0] best_ang [iks_pkg::NumJoints]
);
	import iks_pkg::*;

	localparam int NumPairs = NumJoints / 2;

	iks_ctl_t                   ctl_s6;
	iks_ctl_t                   ctl_s7;
	logic [PairW-1:0]           pair_s6 [NumPairs];
	logic                       ok_s6;
	logic signed [OutAngW-1:0]  map_s6  [NumJoints];
	logic [CostW-1:0]           total_s7;
	logic                       ok_s7;
	logic signed [OutAngW-1:0]  map_s7  [NumJoints];

	logic [CostW-1:0]           best_cost_q;
	logic [CntW-1:0]            best_pos_q;
	logic                       any_valid_q;
	logic signed [OutAngW-1:0]  best_ang_q [NumJoints];
	logic                       out_valid_q;

	logic                       step;
	logic                       better;
	logic                       load_out;
	logic                       all_ok;

	assign all_ok = ok[0] && ok[1] && ok[2] && ok[3] && ok[4] && ok[5];

	// Stage 6 adds lane pairs; stage 7 forms the total. With four-bit weights
	// and distances under 2^19, the total stays well below the 48-bit ceiling.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < NumPairs; p++) begin
				pair_s6[p] <= PairW'(wcost[2*p]) + PairW'(wcost[2*p+1]);
			end
			ok_s6    <= all_ok;
			map_s6   <= mapped;
			total_s7 <= CostW'(pair_s6[0]) + CostW'(pair_s6[1]) + CostW'(pair_s6[2]);
			ok_s7    <= ok_s6;
			map_s7   <= map_s6;
		end
	end

	// Control beside the sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else if (en) begin
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	// A candidate wins only on a strictly lower cost, so ties keep the earlier one.
	assign step     = en && ctl_s7.valid;
	assign better   = ctl_s7.eval && ok_s7 && (total_s7 < best_cost_q);
	assign load_out = step && ctl_s7.last;

	// Running best; the last item of a set closes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_cost_q <= '1;
			best_pos_q  <= '0;
			any_valid_q <= 1'b0;
			for (int j = 0; j < NumJoints; j++) begin
				best_ang_q[j] <= '0;
			end
		end else if (step) begin
			if (ctl_s7.last) begin
				best_cost_q <= '1;
				best_pos_q  <= '0;
				any_valid_q <= 1'b0;
				for (int j = 0; j < NumJoints; j++) begin
					best_ang_q[j] <= '0;
				end
			end else if (better) begin
				best_cost_q <= total_s7;
				best_pos_q  <= ctl_s7.pos;
				any_valid_q <= 1'b1;
				best_ang_q  <= map_s7;
			end
		end
	end

	// Result item register.
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (better) begin
				best_index <= IdxW'(ctl_s7.pos);
				found      <= 1'b1;
				best_ang   <= map_s7;
			end else if (any_valid_q) begin
				best_index <= IdxW'(best_pos_q);
				found      <= 1'b1;
				best_ang   <= best_ang_q;
			end else begin
				best_index <= '0;
				found      <= 1'b0;
				for (int j = 0; j < NumJoints; j++) begin
					best_ang[j] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/ik_solution_selector.sv =====
// ----------------------------------------------------------------------------
// ik_solution_selector
// Chooses the lowest-cost valid six-joint IK candidate among the first eight of each set.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+-------------------------------
//   input    | in  | in_valid / in_ready    | func, angle_j0..5, last
//   result   | out | out_valid / out_ready  | best_index, found, best_j0..5
//   config   | in  | cfg_we                 | cfg_index, cfg_data
//
// One item per cycle is taken unless the pipeline holds; six joint lanes
// run side by side and merge stages sum their costs. The result of a set
// waits in the output register; the whole pipeline holds while it waits.
// Reset clears the set, the current angles and the registers to defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ik_solution_selector (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               func,
	input  logic signed [iks_pkg::InAngW-1:0]  angle_j0,
	input  logic signed [iks_pkg::InAngW-1:0]  angle_j1,
	input  logic signed [iks_pkg::InAngW-1:0]  angle_j2,
	input  logic signed [iks_pkg::InAngW-1:0]  angle_j3,
	input  logic signed [iks_pkg::InAngW-1:0]  angle_j4,
	input  logic signed [iks_pkg::InAngW-1:0]  angle_j5,
	input  logic                               last,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [iks_pkg::IdxW-1:0]           best_index,
	output logic                               found,
	output logic signed [iks_pkg::OutAngW-1:0] best_j0,
	output logic signed [iks_pkg::OutAngW-1:0] best_j1,
	output logic signed [iks_pkg::OutAngW-1:0] best_j2,
	output logic signed [iks_pkg::OutAngW-1:0] best_j3,
	output logic signed [iks_pkg::OutAngW-1:0] best_j4,
	output logic signed [iks_pkg::OutAngW-1:0] best_j5,
	input  logic                               cfg_we,
	input  logic [2:0]                         cfg_index,
	input  logic [iks_pkg::LimW-1:0]           cfg_data
);
	import iks_pkg::*;

	logic                      en;
	logic                      accept;
	logic signed [InAngW-1:0]  angle    [NumJoints];
	logic signed [InAngW-1:0]  cur_q    [NumJoints];
	logic [LimW-1:0]           limits_q [NumJoints];
	logic [WeightsW-1:0]       weights_q;
	logic [NumJoints-1:0]      bias_q;
	logic [CntW-1:0]           cand_count_q;
	logic                      eval;
	iks_ctl_t                  ctl_in;
	iks_ctl_t                  ctl_s1;
	iks_ctl_t                  ctl_s2;
	iks_ctl_t                  ctl_s3;
	iks_ctl_t                  ctl_s4;
	iks_ctl_t                  ctl_s5;
	logic [LaneCostW-1:0]      wcost    [NumJoints];
	logic                      lane_ok  [NumJoints];
	logic signed [OutAngW-1:0] mapped   [NumJoints];
	logic signed [OutAngW-1:0] best_ang [NumJoints];

	assign angle[0] = angle_j0;
	assign angle[1] = angle_j1;
	assign angle[2] = angle_j2;
	assign angle[3] = angle_j3;
	assign angle[4] = angle_j4;
	assign angle[5] = angle_j5;

	// The pipeline moves unless a result is waiting and not being taken.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign accept   = in_valid && in_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NumJoints; j++) begin
				limits_q[j] <= LimitsReset;
			end
			weights_q <= WeightsReset;
			bias_q    <= BiasReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgWeights:  weights_q <= cfg_data[WeightsW-1:0];
				CfgBiasMask: bias_q    <= cfg_data[NumJoints-1:0];
				default:     limits_q[cfg_index] <= cfg_data;
			endcase
		end
	end

	// Current joint angles are loaded by a func=0 item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NumJoints; j++) begin
				cur_q[j] <= '0;
			end
		end else if (accept && !func) begin
			cur_q <= angle;
		end
	end

	// Candidate position within the set; the last item restarts the count.
	assign eval = cand_count_q < CntW'(MaxCand);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_count_q <= '0;
		end else if (accept && func) begin
			if (last) begin
				cand_count_q <= '0;
			end else if (eval) begin
				cand_count_q <= cand_count_q + CntW'(1);
			end
		end
	end

	// Control word that follows each candidate through the lanes.
	always_comb begin
		ctl_in.valid = accept && func;
		ctl_in.eval  = eval;
		ctl_in.last  = last;
		ctl_in.pos   = cand_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// One lane per joint.
	for (genvar g = 0; g < NumJoints; g++) begin : g_lane
		iks_lane u_lane (
			.clk    (clk),
			.en     (en),
			.angle  (angle[g]),
			.cur    (cur_q[g]),
			.limits (limits_q[g]),
			.weight (weights_q[WeightW*g +: WeightW]),
			.bias   (bias_q[g]),
			.wcost  (wcost[g]),
			.ok     (lane_ok[g]),
			.mapped (mapped[g])
		);
	end

	iks_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.ctl_s5     (ctl_s5),
		.wcost      (wcost),
		.ok         (lane_ok),
		.mapped     (mapped),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.best_index (best_index),
		.found      (found),
		.best_ang   (best_ang)
	);

	assign best_j0 = best_ang[0];
	assign best_j1 = best_ang[1];
	assign best_j2 = best_ang[2];
	assign best_j3 = best_ang[3];
	assign best_j4 = best_ang[4];
	assign best_j5 = best_ang[5];

	// The candidate count never passes the set size.
	`ASSERT_ALWAYS(a_count_bound, cand_count_q <= CntW'(MaxCand))
	// A waiting, untaken result blocks new input items.
	`ASSERT_ALWAYS(a_stall_blocks_in, !(out_valid && !out_ready && in_ready))
	// A result without a valid candidate carries zero fields.
	`ASSERT_ALWAYS(a_empty_result,
		!(out_valid && !found) || (best_index == '0 && best_j0 == '0 && best_j5 == '0))
	// Loading current angles leaves the candidate count untouched.
	`ASSERT_NEXT(a_load_keeps_count, accept && !func, $stable(cand_count_q))

endmodule

// ===== verif/ik_solution_selector_tb.sv =====
// ----------------------------------------------------------------------------
// ik_solution_selector_tb
// Self-checking bench for the IK solution selector. Current-angle loads and
// candidate sets go in over the input channel. The bench tracks the wrapping,
// cost and running minimum of every set in its own model and compares each
// chosen solution with the model's choice. Directed sets cover angle extremes,
// tolerance boundaries, ties, reversed limits, wide mapped angles, overfull
// sets and loads in the middle of a set. Random phases then sweep several
// register settings, with random idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ik_solution_selector_tb;
	import iks_pkg::*;

	localparam logic       FuncLoad   = 1'b0;
	localparam logic       FuncCand   = 1'b1;
	localparam logic [2:0] CfgLimits0 = 3'd0;

	localparam int  AngleSpan   = 72000;
	localparam int  PipeLatency = 8;
	localparam int  CycleLimit  = 400000;
	localparam longint CostCap  = (64'sd1 <<< 48) - 1;

	// Register settings used by the random phases.
	localparam int StyleRandom      = 0;
	localparam int StyleZeroCost    = 1;
	localparam int StyleFullRange   = 2;
	localparam int StyleRawExtremes = 3;
	localparam int StyleNarrow      = 4;

	typedef struct {
		logic                     func;
		logic signed [InAngW-1:0] ang [NumJoints];
		logic                     last;
	} ik_item_t;

	typedef struct {
		logic [IdxW-1:0]    idx;
		logic               found;
		logic [OutAngW-1:0] ang [NumJoints];
	} choice_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = 1'b0;
	logic signed [InAngW-1:0] angle_j0 = '0;
	logic signed [InAngW-1:0] angle_j1 = '0;
	logic signed [InAngW-1:0] angle_j2 = '0;
	logic signed [InAngW-1:0] angle_j3 = '0;
	logic signed [InAngW-1:0] angle_j4 = '0;
	logic signed [InAngW-1:0] angle_j5 = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [IdxW-1:0] best_index;
	logic found;
	logic signed [OutAngW-1:0] best_j0;
	logic signed [OutAngW-1:0] best_j1;
	logic signed [OutAngW-1:0] best_j2;
	logic signed [OutAngW-1:0] best_j3;
	logic signed [OutAngW-1:0] best_j4;
	logic signed [OutAngW-1:0] best_j5;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [LimW-1:0] cfg_data = '0;

	// Model copy of the registers and of the selection state.
	logic [LimW-1:0]      lim_cfg [NumJoints];
	logic [WeightsW-1:0]  weight_cfg;
	logic [NumJoints-1:0] bias_cfg;
	longint cur_ang [NumJoints];
	longint best_cost;
	int     best_pos;
	bit     any_valid;
	longint best_ang [NumJoints];
	int     cand_cnt;

	choice_t choice_q [$];

	bit no_idle = 1'b0;
	int fail_cnt = 0;
	int cycle_cnt = 0;
	int items_sent = 0;
	int cands_sent = 0;
	int cfg_writes = 0;
	int results_checked = 0;
	int found_sets = 0;

	ik_solution_selector u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.angle_j0   (angle_j0),
		.angle_j1   (angle_j1),
		.angle_j2   (angle_j2),
		.angle_j3   (angle_j3),
		.angle_j4   (angle_j4),
		.angle_j5   (angle_j5),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.best_index (best_index),
		.found      (found),
		.best_j0    (best_j0),
		.best_j1    (best_j1),
		.best_j2    (best_j2),
		.best_j3    (best_j3),
		.best_j4    (best_j4),
		.best_j5    (best_j5),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CycleLimit) begin
			$error("run did not finish within %0d cycles", CycleLimit);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Sign-extends an 18-bit angle or limit.
	function automatic longint angle_of(input logic [InAngW-1:0] v);
		return $signed(v);
	endfunction

	function automatic logic [LimW-1:0] pack_limits(input int lo_v, input int hi_v);
		return {InAngW'(hi_v), InAngW'(lo_v)};
	endfunction

	// Closes the running set.
	function automatic void clear_set();
		best_cost = CostCap;
		best_pos = 0;
		any_valid = 1'b0;
		cand_cnt = 0;
		for (int j = 0; j < NumJoints; j++) begin
			best_ang[j] = 0;
		end
	endfunction

	function automatic void model_reset();
		for (int j = 0; j < NumJoints; j++) begin
			lim_cfg[j] = LimitsReset;
			cur_ang[j] = 0;
		end
		weight_cfg = WeightsReset;
		bias_cfg = BiasReset;
		clear_set();
	endfunction

	// Applies one accepted item to the model and queues the choice it closes.
	function automatic void track_selection(input ik_item_t it);
		longint  mapped;
		longint  lo_b, hi_b, d, w, cost;
		longint  cand_ang [NumJoints];
		bit      ok;
		choice_t res;
		if (it.func == FuncLoad) begin
			for (int j = 0; j < NumJoints; j++) begin
				cur_ang[j] = it.ang[j];
			end
			return;
		end
		if (cand_cnt < MaxCand) begin
			ok = 1'b1;
			cost = 0;
			for (int j = 0; j < NumJoints && ok; j++) begin
				// Wrap by whole turns into the widened limits, then test strictly.
				lo_b = angle_of(lim_cfg[j][InAngW-1:0]) - Tolerance;
				hi_b = angle_of(lim_cfg[j][LimW-1:InAngW]) + Tolerance;
				mapped = it.ang[j];
				while (mapped < lo_b) mapped += Turn;
				while (mapped > hi_b) mapped -= Turn;
				cand_ang[j] = mapped;
				if (!(mapped > lo_b && mapped < hi_b)) begin
					ok = 1'b0;
				end else begin
					d = mapped - cur_ang[j];
					if (bias_cfg[j]) d += (mapped < 0) ? -mapped : mapped;
					if (d < 0) d = -d;
					w = weight_cfg[WeightW*j +: WeightW];
					cost += w * d * d;
					if (cost > CostCap) cost = CostCap;
				end
			end
			if (ok && cost < best_cost) begin
				best_cost = cost;
				best_pos = cand_cnt;
				any_valid = 1'b1;
				for (int j = 0; j < NumJoints; j++) begin
					best_ang[j] = cand_ang[j];
				end
			end
			cand_cnt++;
		end
		if (it.last) begin
			res.idx = any_valid ? IdxW'(best_pos) : '0;
			res.found = any_valid;
			for (int j = 0; j < NumJoints; j++) begin
				res.ang[j] = any_valid ? OutAngW'(best_ang[j]) : '0;
			end
			if (any_valid) found_sets++;
			choice_q.push_back(res);
			clear_set();
		end
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(30, 6);
	endfunction

	function automatic ik_item_t mk_item(input logic f, input int a0, input int a1,
			input int a2, input int a3, input int a4, input int a5, input logic lst);
		ik_item_t it;
		it.func = f;
		it.ang[0] = a0;
		it.ang[1] = a1;
		it.ang[2] = a2;
		it.ang[3] = a3;
		it.ang[4] = a4;
		it.ang[5] = a5;
		it.last = lst;
		return it;
	endfunction

	// Random angle: span ends, zero, uniform, near the current angle, or aimed
	// into the joint's limits a few turns away.
	function automatic int rand_angle(input int j);
		int r, a, lo_v, hi_v;
		r = $urandom_range(99);
		if (r < 2) return -AngleSpan;
		if (r < 4) return AngleSpan;
		if (r < 5) return 0;
		if (r < 40) return int'($urandom_range(2 * AngleSpan)) - AngleSpan;
		if (r < 65) begin
			a = int'(cur_ang[j]) + int'($urandom_range(1000)) - 500;
		end else begin
			lo_v = int'(angle_of(lim_cfg[j][InAngW-1:0]));
			hi_v = int'(angle_of(lim_cfg[j][LimW-1:InAngW]));
			a = (hi_v < lo_v) ? lo_v : lo_v + int'($urandom_range(hi_v - lo_v));
			a += Turn * (int'($urandom_range(4)) - 2);
		end
		if (a > AngleSpan) a = AngleSpan;
		if (a < -AngleSpan) a = -AngleSpan;
		return a;
	endfunction

	function automatic ik_item_t rand_item(input logic f);
		ik_item_t it;
		it.func = f;
		it.last = 1'b0;
		for (int j = 0; j < NumJoints; j++) begin
			it.ang[j] = rand_angle(j);
		end
		return it;
	endfunction

	function automatic logic [LimW-1:0] pick_limits(input int style, input int j);
		int lo_v, hi_v;
		case (style)
			StyleFullRange: begin
				return pack_limits(-131072, 131071);
			end
			StyleRawExtremes: begin
				if (j == 0) return '0;
				if (j == 1) return {LimW{1'b1}};
				return LimitsReset;
			end
			StyleNarrow: begin
				lo_v = int'($urandom_range(200000)) - 100000;
				hi_v = lo_v + int'($urandom_range(3000));
				return pack_limits(lo_v, hi_v);
			end
			default: begin
				if ($urandom_range(3) == 0) return LimitsReset;
				lo_v = -int'($urandom_range(131072));
				hi_v = int'($urandom_range(131071));
				return pack_limits(lo_v, hi_v);
			end
		endcase
	endfunction

	// Sends one item, holding it until it is taken, then updates the model.
	task automatic offer_item(input ik_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= it.func;
		angle_j0 <= it.ang[0];
		angle_j1 <= it.ang[1];
		angle_j2 <= it.ang[2];
		angle_j3 <= it.ang[3];
		angle_j4 <= it.ang[4];
		angle_j5 <= it.ang[5];
		last <= it.last;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (it.func == FuncCand) cands_sent++;
		track_selection(it);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [LimW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx < CfgWeights) lim_cfg[idx] = val;
		else if (idx == CfgWeights) weight_cfg = val[WeightsW-1:0];
		else bias_cfg = val[NumJoints-1:0];
		cfg_writes++;
	endtask

	// Drains the block: all choices back, then the pipeline given time to empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (choice_q.size() != 0) @(posedge clk);
		repeat (2 * PipeLatency) @(posedge clk);
	endtask

	task automatic program_config(input int style);
		for (int j = 0; j < NumJoints; j++) begin
			write_reg(CfgLimits0 + 3'(j), pick_limits(style, j));
		end
		case (style)
			StyleZeroCost: begin
				write_reg(CfgWeights, '0);
				write_reg(CfgBiasMask, '0);
			end
			StyleFullRange: begin
				write_reg(CfgWeights, {WeightsW{1'b1}});
				write_reg(CfgBiasMask, {NumJoints{1'b1}});
			end
			default: begin
				write_reg(CfgWeights, LimW'($urandom_range(24'hFFFFFF)));
				write_reg(CfgBiasMask, LimW'($urandom_range(63)));
			end
		endcase
	endtask

	// One random sequence: mostly a well-formed set, sometimes loose items.
	task automatic send_random_set();
		ik_item_t it, prev, ld;
		int n_cand;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(4, 1)) begin
				it = rand_item(1'($urandom_range(1)));
				it.last = 1'($urandom_range(1));
				offer_item(it);
			end
			return;
		end
		if ($urandom_range(1)) begin
			ld = rand_item(FuncLoad);
			ld.last = 1'($urandom_range(1));
			offer_item(ld);
		end
		n_cand = ($urandom_range(9) == 0) ? $urandom_range(12, 9) : $urandom_range(6, 1);
		for (int i = 0; i < n_cand; i++) begin
			if ($urandom_range(19) == 0) begin
				ld = rand_item(FuncLoad);
				ld.last = 1'($urandom_range(1));
				offer_item(ld);
			end
			if (i > 0 && $urandom_range(6) == 0) it = prev;
			else it = rand_item(FuncCand);
			it.last = (i == n_cand - 1);
			offer_item(it);
			prev = it;
		end
	endtask

	// Default registers: extremes, tolerance boundary and a tie.
	task automatic test_reset_config();
		offer_item(mk_item(FuncLoad, 72000, -72000, 0, 36000, -36000, 1, 1'b1));
		offer_item(mk_item(FuncCand, 72000, 72000, 72000, 72000, 72000, 72000, 1'b0));
		offer_item(mk_item(FuncCand, -72000, -72000, -72000, -72000, -72000, -72000, 1'b0));
		offer_item(mk_item(FuncCand, 0, 0, 0, 0, 0, 0, 1'b0));
		offer_item(mk_item(FuncCand, 0, 0, 0, 0, 0, 0, 1'b1));
		// On the widened limit, which the strict test rejects, so the set has no valid candidate.
		offer_item(mk_item(FuncCand, 36001, 0, 0, 0, 0, 0, 1'b1));
		offer_item(mk_item(FuncCand, 36000, -36000, 36000, -36000, 36000, -36000, 1'b1));
	endtask

	// Reversed limits, a mapped angle beyond 17 bits, and an overfull set.
	task automatic test_special_cases();
		settle();
		write_reg(CfgLimits0, pack_limits(1000, -1000));
		offer_item(mk_item(FuncCand, 500, 0, 0, 0, 0, 0, 1'b0));
		offer_item(mk_item(FuncCand, -500, 100, 0, 0, 0, 0, 1'b1));
		settle();
		write_reg(CfgLimits0, LimitsReset);
		write_reg(CfgLimits0 + 3'd1, pack_limits(60000, 131071));
		offer_item(mk_item(FuncCand, 0, 70000, 0, 0, 0, 0, 1'b0));
		offer_item(mk_item(FuncCand, 100, -72000, 0, 0, 0, 0, 1'b1));
		settle();
		write_reg(CfgWeights, {WeightsW{1'b1}});
		write_reg(CfgBiasMask, {NumJoints{1'b1}});
		offer_item(mk_item(FuncLoad, 0, 0, 0, 0, 0, 0, 1'b0));
		// The best candidates come after the set is full and must be skipped.
		for (int i = 0; i < 10; i++) begin
			if (i < MaxCand)
				offer_item(mk_item(FuncCand, 800 * (8 - i), 800 * (8 - i), 800 * (8 - i),
					800 * (8 - i), 800 * (8 - i), 800 * (8 - i), 1'b0));
			else
				offer_item(mk_item(FuncCand, 0, 0, 0, 0, 0, 0, 1'(i == 9)));
			if (i == 3) offer_item(mk_item(FuncLoad, 200, 200, 200, 200, 200, 200, 1'b0));
		end
		settle();
	endtask

	task automatic test_random_sets(input int n_items, input int style);
		int start;
		settle();
		program_config(style);
		start = items_sent;
		while (items_sent - start < n_items) send_random_set();
	endtask

	task automatic test_back_to_back(input int n_items);
		no_idle = 1'b1;
		test_random_sets(n_items, StyleRandom);
		settle();
		no_idle = 1'b0;
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_cnt++;
		end
	endtask

	// Compares every accepted result with the oldest expected choice.
	always @(posedge clk) begin : result_check
		choice_t want;
		logic signed [OutAngW-1:0] got_ang [NumJoints];
		if (arst_n && out_valid && out_ready) begin
			got_ang[0] = best_j0;
			got_ang[1] = best_j1;
			got_ang[2] = best_j2;
			got_ang[3] = best_j3;
			got_ang[4] = best_j4;
			got_ang[5] = best_j5;
			if (choice_q.size() == 0) begin
				$error("result with no choice pending: index %0d, found %0d", best_index, found);
				fail_cnt++;
			end else begin
				want = choice_q.pop_front();
				results_checked++;
				check_field("best_index", want.idx, best_index);
				check_field("found", want.found, found);
				for (int j = 0; j < NumJoints; j++) begin
					check_field($sformatf("best_j%0d", j), $signed(want.ang[j]), got_ang[j]);
				end
			end
		end
	end

	// Result side: runs of ready broken by stalls of random length, unless no_idle is set.
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat (1 + pick_gap()) @(posedge clk);
			if (!no_idle && $urandom_range(1)) begin
				out_ready <= 1'b0;
				repeat (1 + pick_gap()) @(posedge clk);
			end
		end
	end

	// Test sequence.
	initial begin
		model_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_special_cases();
		test_random_sets(200, StyleRandom);
		test_random_sets(130, StyleZeroCost);
		test_random_sets(150, StyleFullRange);
		test_random_sets(120, StyleRawExtremes);
		test_random_sets(130, StyleNarrow);
		test_random_sets(200, StyleRandom);
		test_back_to_back(160);
		settle();
		$display("Covered %0d items (%0d candidates) over %0d register writes.",
			items_sent, cands_sent, cfg_writes);
		$display("Checked %0d chosen solutions, %0d of them from sets with a valid candidate.",
			results_checked, found_sets);
		if (fail_cnt == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
